// ----- src/c8ie_pkg.sv -----
// ----------------------------------------------------------------------------
// c8ie_pkg
// Shared types and constants for the chip-8 instruction execute block.
// ----------------------------------------------------------------------------
`default_nettype none

package c8ie_pkg;

  localparam int unsigned AddrW        = 12;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned RegIdxW      = 4;
  localparam int unsigned NumGenRegs   = 16;
  localparam int unsigned StackDepthDef = 16;

  localparam logic [AddrW-1:0] PcReset    = 12'h200;
  localparam logic [AddrW-1:0] PcStep     = 12'd2;
  localparam logic [ByteW-1:0] TimerReset = 8'd60;

  // opcode groups (top nibble)
  localparam logic [3:0] GrpSys     = 4'h0;
  localparam logic [3:0] GrpJump    = 4'h1;
  localparam logic [3:0] GrpCall    = 4'h2;
  localparam logic [3:0] GrpSetIdx  = 4'hA;
  localparam logic [3:0] GrpJumpV0  = 4'hB;
  localparam logic [3:0] GrpRand    = 4'hC;

  // full opcodes of the system group
  localparam logic [15:0] OpCls = 16'h00E0;
  localparam logic [15:0] OpRet = 16'h00EE;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StUnknown   = 2'd1,
    StOverflow  = 2'd2,
    StUnderflow = 2'd3
  } status_e;

  typedef struct packed {
    logic [AddrW-1:0]   next_pc;
    logic [AddrW-1:0]   index_value;
    logic               clear_screen;
    logic               reg_written;
    logic [RegIdxW-1:0] reg_number;
    logic [ByteW-1:0]   reg_value;
    logic [ByteW-1:0]   delay_value;
    logic [ByteW-1:0]   sound_value;
    logic               beep;
    status_e            status;
  } result_t;

  // core -> return stack
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [AddrW-1:0] data;
  } stk_req_t;

  // return stack -> core
  typedef struct packed {
    logic             empty;
    logic             full;
    logic [AddrW-1:0] top;
  } stk_stat_t;

endpackage

`default_nettype wire

// ----- src/c8ie_stack.sv -----
// ----------------------------------------------------------------------------
// c8ie_stack
// Return address stack built as a shift stack: the top entry is always slot 0.
// ----------------------------------------------------------------------------
`default_nettype none

module c8ie_stack #(
  parameter int unsigned StackDepth = c8ie_pkg::StackDepthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire c8ie_pkg::stk_req_t  req_i,
  output      c8ie_pkg::stk_stat_t stat_o
);
  import c8ie_pkg::*;

  localparam int unsigned CntW = $clog2(StackDepth + 1);

  logic [AddrW-1:0] entries_q [StackDepth];
  logic [CntW-1:0]  count_q, count_d;

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      entries_q[0] <= req_i.data;
      for (int i = 1; i < StackDepth; i++) begin
        entries_q[i] <= entries_q[i-1];
      end
    end else if (req_i.pop) begin
      for (int i = 0; i < StackDepth - 1; i++) begin
        entries_q[i] <= entries_q[i+1];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (req_i.push) begin
      count_d = count_q + CntW'(1);
    end else if (req_i.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(StackDepth));
  assign stat_o.top   = entries_q[0];

endmodule

`default_nettype wire

// ----- src/c8ie_core.sv -----
// ----------------------------------------------------------------------------
// c8ie_core
// Architectural state and single-pass execute logic for one instruction.
// ----------------------------------------------------------------------------
`default_nettype none

module c8ie_core #(
  parameter int unsigned StackDepth = c8ie_pkg::StackDepthDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              exec_i,
  input  wire logic [15:0]       instr_i,
  input  wire logic [7:0]        rnd_i,
  output      c8ie_pkg::result_t result_o
);
  import c8ie_pkg::*;

  logic [AddrW-1:0] pc_q, pc_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [ByteW-1:0] delay_q, delay_d;
  logic [ByteW-1:0] sound_q, sound_d;
  logic [ByteW-1:0] vregs_q [NumGenRegs];

  logic [3:0]         grp;
  logic [AddrW-1:0]   nnn;
  logic [RegIdxW-1:0] x;
  logic [ByteW-1:0]   nn;
  logic [AddrW-1:0]   pc_inc;

  logic               clr;
  logic               wr;
  logic [RegIdxW-1:0] wnum;
  logic [ByteW-1:0]   wval;
  status_e            status;
  logic               push, pop;

  stk_req_t  stk_req;
  stk_stat_t stk_stat;

  assign grp    = instr_i[15:12];
  assign nnn    = instr_i[11:0];
  assign x      = instr_i[11:8];
  assign nn     = instr_i[7:0];
  assign pc_inc = pc_q + PcStep;

  always_comb begin
    pc_d   = pc_q;
    idx_d  = idx_q;
    clr    = 1'b0;
    wr     = 1'b0;
    wnum   = '0;
    wval   = '0;
    status = StOk;
    push   = 1'b0;
    pop    = 1'b0;
    unique case (grp)
      GrpSys: begin
        if (instr_i == OpCls) begin
          clr  = 1'b1;
          pc_d = pc_inc;
        end else if (instr_i == OpRet) begin
          if (stk_stat.empty) begin
            status = StUnderflow;
          end else begin
            pop  = 1'b1;
            pc_d = stk_stat.top + PcStep;
          end
        end else begin
          status = StUnknown;
        end
      end
      GrpJump: begin
        pc_d = nnn;
      end
      GrpCall: begin
        if (stk_stat.full) begin
          status = StOverflow;
        end else begin
          push = 1'b1;
          pc_d = nnn;
        end
      end
      GrpSetIdx: begin
        idx_d = nnn;
        pc_d  = pc_inc;
      end
      GrpJumpV0: begin
        pc_d = nnn + {{(AddrW-ByteW){1'b0}}, vregs_q[0]};
      end
      GrpRand: begin
        wr   = 1'b1;
        wnum = x;
        wval = nn & rnd_i;
        pc_d = pc_inc;
      end
      default: begin
        status = StUnknown;
      end
    endcase
  end

  // timers count down to zero and stick there
  assign delay_d = (delay_q != '0) ? delay_q - 8'd1 : delay_q;
  assign sound_d = (sound_q != '0) ? sound_q - 8'd1 : sound_q;

  // call pushes its own address
  assign stk_req.push = exec_i & push;
  assign stk_req.pop  = exec_i & pop;
  assign stk_req.data = pc_q;

  c8ie_stack #(
    .StackDepth(StackDepth)
  ) u_stack (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (stk_req),
    .stat_o(stk_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= PcReset;
      idx_q   <= '0;
      delay_q <= TimerReset;
      sound_q <= TimerReset;
      for (int i = 0; i < NumGenRegs; i++) begin
        vregs_q[i] <= '0;
      end
    end else if (exec_i) begin
      pc_q    <= pc_d;
      idx_q   <= idx_d;
      delay_q <= delay_d;
      sound_q <= sound_d;
      if (wr) begin
        vregs_q[wnum] <= wval;
      end
    end
  end

  assign result_o.next_pc      = pc_d;
  assign result_o.index_value  = idx_d;
  assign result_o.clear_screen = clr;
  assign result_o.reg_written  = wr;
  assign result_o.reg_number   = wnum;
  assign result_o.reg_value    = wval;
  assign result_o.delay_value  = delay_d;
  assign result_o.sound_value  = sound_d;
  assign result_o.beep         = (sound_q == 8'd1);
  assign result_o.status       = status;

endmodule

`default_nettype wire

// ----- src/chip8_instruction_execute.sv -----
// ----------------------------------------------------------------------------
// chip8_instruction_execute
// Executes one fetched chip-8 opcode per request and reports the new state.
// ----------------------------------------------------------------------------
// channel  dir  bits  contents (lsb first)
// s_axis   in   24    instruction[15:0], random_byte[23:16]
// m_axis   out  64    next_pc, index_value, clear_screen, reg_written,
//                     reg_number, reg_value, delay_value, sound_value,
//                     beep, status, zero pad
//
// one request per cycle sustained while m_axis is not stalled; the request sits
// in the input register, then is executed into the result register.
// the execute step is a single pass over the pc, index, timers and the
// shift-style return stack, so nothing iterates.
// reset puts pc at 0x200, timers at 60, index, registers and stack empty.
// a stalled result holds the pipe; the input register still takes one
// request while the result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module chip8_instruction_execute #(
  parameter int unsigned StackDepth = c8ie_pkg::StackDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // instruction, random_byte
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [63:0] m_axis_tdata_o    // next_pc, index_value, clear_screen,
                                             // reg_written, reg_number, reg_value,
                                             // delay_value, sound_value, beep, status
);
  import c8ie_pkg::*;

  logic        in_valid_q, in_valid_d;
  logic [15:0] instr_q;
  logic [7:0]  rnd_q;
  logic        out_valid_q, out_valid_d;
  result_t     res_q;
  result_t     res;

  logic advance;
  logic exec;
  logic s_fire;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign exec            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (exec) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      instr_q <= s_axis_tdata_i[15:0];
      rnd_q   <= s_axis_tdata_i[23:16];
    end
    if (exec) begin
      res_q <= res;
    end
  end

  c8ie_core #(
    .StackDepth(StackDepth)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .exec_i  (exec),
    .instr_i (instr_q),
    .rnd_i   (rnd_q),
    .result_o(res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0,
                            res_q.status,
                            res_q.beep,
                            res_q.sound_value,
                            res_q.delay_value,
                            res_q.reg_value,
                            res_q.reg_number,
                            res_q.reg_written,
                            res_q.clear_screen,
                            res_q.index_value,
                            res_q.next_pc};

endmodule

`default_nettype wire
